FILE: design/leg_fk_pkg.sv
// ----------------------------------------------------------------------------
// Leg forward kinematics package
// Widths, register indexes, arctangent table and rounding helpers shared by
// the leg forward kinematics pipeline.
// ----------------------------------------------------------------------------
package leg_fk_pkg;

  localparam int ANGLE_WIDTH    = 16;
  localparam int POSITION_WIDTH = 18;
  localparam int LEN_WIDTH      = 15;
  localparam int CORDIC_STEPS   = 24;
  localparam int CW             = 33;
  localparam int VW             = 34;
  localparam int PW             = CW + VW;
  localparam int QW             = VW - 13;
  localparam int EW             = ((POSITION_WIDTH > QW + 1) ? POSITION_WIDTH : QW + 1) + 1;

  localparam logic signed [CW-1:0] CORDIC_INIT = CW'(652032874);

  localparam logic [LEN_WIDTH-1:0] UPPER_RESET  = LEN_WIDTH'(14798);
  localparam logic [LEN_WIDTH-1:0] LOWER_RESET  = LEN_WIDTH'(13173);
  localparam logic [LEN_WIDTH-1:0] OFFSET_RESET = LEN_WIDTH'(4758);

  typedef enum logic [1:0] {
    REG_UPPER  = 2'd0,
    REG_LOWER  = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] cp;
    logic signed [CW-1:0] sp;
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] sr;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] sy;
  } trig_t;

  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:       r = CW'(536870912);
      1:       r = CW'(316933406);
      2:       r = CW'(167458907);
      3:       r = CW'(85004756);
      4:       r = CW'(42667331);
      5:       r = CW'(21354465);
      6:       r = CW'(10679838);
      7:       r = CW'(5340245);
      8:       r = CW'(2670163);
      9:       r = CW'(1335087);
      10:      r = CW'(667544);
      11:      r = CW'(333772);
      12:      r = CW'(166886);
      13:      r = CW'(83443);
      14:      r = CW'(41722);
      15:      r = CW'(20861);
      16:      r = CW'(10430);
      17:      r = CW'(5215);
      18:      r = CW'(2608);
      19:      r = CW'(1304);
      20:      r = CW'(652);
      21:      r = CW'(326);
      22:      r = CW'(163);
      23:      r = CW'(81);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [VW-1:0] rnd30(input logic signed [PW:0] v);
    logic signed [PW:0] t;
    t = v + $signed({{(PW-29){1'b0}}, 1'b1, 29'b0});
    return VW'(t >>> 30);
  endfunction

  function automatic logic signed [QW-1:0] q16(input logic signed [VW-1:0] v);
    logic signed [VW:0] t;
    t = $signed({v[VW-1], v}) + $signed({{(VW-13){1'b0}}, 1'b1, 13'b0});
    return QW'(t >>> 14);
  endfunction

  function automatic logic signed [POSITION_WIDTH-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    logic signed [POSITION_WIDTH-1:0] r;
    hi = $signed({{(EW-POSITION_WIDTH+1){1'b0}}, {(POSITION_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      r = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
    end else begin
      r = v[POSITION_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/leg_forward_kinematics_top.sv
// Pipeline stages: 1 input stage, 24 CORDIC stages, 1 sign stage, 8 multiply/accumulate
// stages, 1 output stage.
// Throughput: one item per cycle unless stalled; CORDIC and rotation multipliers are fully pipelined.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall while out_valid is high.
// Reset (synchronous, rst_n low) clears all valid bits and loads the default link lengths.
// ----------------------------------------------------------------------------
// Leg forward kinematics top level
// Computes knee and ankle positions of a four-joint leg from its joint angles
// using four pipelined CORDIC lanes and a chain of pipelined rotations.
// ----------------------------------------------------------------------------
module leg_forward_kinematics_top (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic signed [leg_fk_pkg::ANGLE_WIDTH-1:0]     in_hip_pitch,
  input  logic signed [leg_fk_pkg::ANGLE_WIDTH-1:0]     in_hip_roll,
  input  logic signed [leg_fk_pkg::ANGLE_WIDTH-1:0]     in_hip_yaw,
  input  logic signed [leg_fk_pkg::ANGLE_WIDTH-1:0]     in_knee_angle,
  input  logic                                          in_right_side,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic signed [leg_fk_pkg::POSITION_WIDTH-1:0]  out_knee_x,
  output logic signed [leg_fk_pkg::POSITION_WIDTH-1:0]  out_knee_y,
  output logic signed [leg_fk_pkg::POSITION_WIDTH-1:0]  out_knee_z,
  output logic signed [leg_fk_pkg::POSITION_WIDTH-1:0]  out_ankle_x,
  output logic signed [leg_fk_pkg::POSITION_WIDTH-1:0]  out_ankle_y,
  output logic signed [leg_fk_pkg::POSITION_WIDTH-1:0]  out_ankle_z,
  input  logic                                          cfg_psel,
  input  logic                                          cfg_penable,
  input  logic                                          cfg_pwrite,
  input  logic [3:0]                                    cfg_paddr,
  input  logic [31:0]                                   cfg_pwdata,
  output logic [31:0]                                   cfg_prdata,
  output logic                                          cfg_pready
);

  localparam int AW  = leg_fk_pkg::ANGLE_WIDTH;
  localparam int CW  = leg_fk_pkg::CW;
  localparam int VW  = leg_fk_pkg::VW;
  localparam int PW  = leg_fk_pkg::PW;
  localparam int EW  = leg_fk_pkg::EW;
  localparam int LW  = leg_fk_pkg::LEN_WIDTH;
  localparam int NS  = leg_fk_pkg::CORDIC_STEPS;
  localparam int POS = leg_fk_pkg::POSITION_WIDTH;

  logic [LW-1:0] upper_r;
  logic [LW-1:0] lower_r;
  logic [LW-1:0] offset_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= leg_fk_pkg::UPPER_RESET;
      lower_r  <= leg_fk_pkg::LOWER_RESET;
      offset_r <= leg_fk_pkg::OFFSET_RESET;
    end else if (cfg_wr) begin
      case (leg_fk_pkg::reg_idx_t'(cfg_paddr[3:2]))
        leg_fk_pkg::REG_UPPER:  upper_r  <= cfg_pwdata[LW-1:0];
        leg_fk_pkg::REG_LOWER:  lower_r  <= cfg_pwdata[LW-1:0];
        leg_fk_pkg::REG_OFFSET: offset_r <= cfg_pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (leg_fk_pkg::reg_idx_t'(cfg_paddr[3:2]))
      leg_fk_pkg::REG_UPPER:  cfg_prdata = {{(32-LW){1'b0}}, upper_r};
      leg_fk_pkg::REG_LOWER:  cfg_prdata = {{(32-LW){1'b0}}, lower_r};
      leg_fk_pkg::REG_OFFSET: cfg_prdata = {{(32-LW){1'b0}}, offset_r};
      default:                cfg_prdata = '0;
    endcase
  end

  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // CORDIC lanes: 0 hip pitch, 1 hip roll, 2 hip yaw, 3 knee.
  logic [AW-1:0]        ang [4];
  logic signed [CW-1:0] cx_r [NS+1][4];
  logic signed [CW-1:0] cy_r [NS+1][4];
  logic signed [CW-1:0] cz_r [NS+1][4];
  logic [3:0]           fl_r [NS+1];
  logic [NS:0]          sdc_r;
  logic [NS:0]          cv_r;

  assign ang[0] = in_hip_pitch;
  assign ang[1] = in_hip_roll;
  assign ang[2] = in_hip_yaw;
  assign ang[3] = in_knee_angle;

  for (genvar k = 0; k < 4; k++) begin : g_lane_in
    logic [31:0] turn;
    logic        flip;
    assign turn = {ang[k], {(32-AW){1'b0}}};
    assign flip = turn[31] ^ turn[30];
    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[0][k] <= leg_fk_pkg::CORDIC_INIT;
        cy_r[0][k] <= '0;
        cz_r[0][k] <= $signed({{(CW-31){turn[31] ^ flip}}, turn[30:0]});
        fl_r[0][k] <= flip;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    for (genvar k = 0; k < 4; k++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz_r[i][k][CW-1]) begin
            cx_r[i+1][k] <= cx_r[i][k] - (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] + (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] - leg_fk_pkg::atan_turn(i);
          end else begin
            cx_r[i+1][k] <= cx_r[i][k] + (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] - (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] + leg_fk_pkg::atan_turn(i);
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[i+1]  <= fl_r[i];
        sdc_r[i+1] <= sdc_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sdc_r[0] <= in_right_side;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (en) begin
      cv_r <= {cv_r[NS-1:0], in_valid};
    end
  end

  // Rotation pipeline: pv_r/sd_r index 0 sign, 1..8 product and sum stages.
  logic [8:0]           pv_r;
  logic [8:0]           sd_r;
  logic signed [CW-1:0] tc_r [4];
  logic signed [CW-1:0] ts_r [4];

  leg_fk_pkg::trig_t    tr1_r, tr2_r, tr3_r, tr4_r, tr5_r, tr6_r;
  leg_fk_pkg::trig_t    tr0;
  logic signed [VW-1:0] neg_u;
  logic signed [VW-1:0] neg_l;

  logic signed [PW-1:0] p1_ky_r, p1_kz_r, p1_ax_r, p1_az_r;
  logic signed [VW-1:0] a1_ky_r, a1_kz_r, a1_ax_r, a1_az_r;
  logic signed [PW-1:0] p2_kx_r, p2_kz_r, p2_ax_r, p2_ay_r;
  logic signed [VW-1:0] p2_ky_r, p2_az_r;
  logic signed [VW-1:0] a2_kx_r, a2_ky_r, a2_kz_r, a2_ax_r, a2_ay_r, a2_az_r;
  logic signed [PW-1:0] p3_m0_r, p3_m1_r, p3_m2_r, p3_m3_r;
  logic signed [VW-1:0] p3_kx_r, p3_ky_r, p3_kz_r, p3_ax_r;
  logic signed [VW-1:0] a3_kx_r, a3_ky_r, a3_kz_r, a3_ax_r, a3_ay_r, a3_az_r;
  logic signed [PW-1:0] p4_n0_r, p4_n1_r, p4_n2_r, p4_n3_r;
  logic signed [VW-1:0] p4_kx_r, p4_ky_r, p4_kz_r, p4_ay_r;
  logic signed [VW-1:0] a4_kx_r, a4_ky_r, a4_kz_r, a4_ax_r, a4_ay_r, a4_az_r;

  assign neg_u = -$signed({{(VW-LW-14){1'b0}}, upper_r, 14'b0});
  assign neg_l = -$signed({{(VW-LW-14){1'b0}}, lower_r, 14'b0});

  always_comb begin
    tr0.cp = tc_r[0];
    tr0.sp = ts_r[0];
    tr0.cr = tc_r[1];
    tr0.sr = ts_r[1];
    tr0.cy = tc_r[2];
    tr0.sy = ts_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[7:0], cv_r[NS]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r <= {sd_r[7:0], sdc_r[NS]};
      for (int k = 0; k < 4; k++) begin
        tc_r[k] <= fl_r[NS][k] ? -cx_r[NS][k] : cx_r[NS][k];
        ts_r[k] <= fl_r[NS][k] ? -cy_r[NS][k] : cy_r[NS][k];
      end

      // Knee roll, ankle knee pitch.
      p1_ky_r <= -(ts_r[1] * neg_u);
      p1_kz_r <= tc_r[1] * neg_u;
      p1_ax_r <= ts_r[3] * neg_l;
      p1_az_r <= tc_r[3] * neg_l;
      tr1_r   <= tr0;

      a1_ky_r <= leg_fk_pkg::rnd30($signed({p1_ky_r[PW-1], p1_ky_r}));
      a1_kz_r <= leg_fk_pkg::rnd30($signed({p1_kz_r[PW-1], p1_kz_r}));
      a1_ax_r <= leg_fk_pkg::rnd30($signed({p1_ax_r[PW-1], p1_ax_r}));
      a1_az_r <= leg_fk_pkg::rnd30($signed({p1_az_r[PW-1], p1_az_r}));
      tr2_r   <= tr1_r;

      // Knee pitch, ankle yaw.
      p2_kx_r <= tr2_r.sp * a1_kz_r;
      p2_kz_r <= tr2_r.cp * a1_kz_r;
      p2_ax_r <= tr2_r.cy * a1_ax_r;
      p2_ay_r <= tr2_r.sy * a1_ax_r;
      p2_ky_r <= a1_ky_r;
      p2_az_r <= a1_az_r;
      tr3_r   <= tr2_r;

      a2_kx_r <= leg_fk_pkg::rnd30($signed({p2_kx_r[PW-1], p2_kx_r}));
      a2_kz_r <= leg_fk_pkg::rnd30($signed({p2_kz_r[PW-1], p2_kz_r}));
      a2_ax_r <= leg_fk_pkg::rnd30($signed({p2_ax_r[PW-1], p2_ax_r}));
      a2_ay_r <= leg_fk_pkg::rnd30($signed({p2_ay_r[PW-1], p2_ay_r}));
      a2_ky_r <= p2_ky_r;
      a2_az_r <= p2_az_r;
      tr4_r   <= tr3_r;

      // Ankle roll.
      p3_m0_r <= tr4_r.cr * a2_ay_r;
      p3_m1_r <= tr4_r.sr * a2_az_r;
      p3_m2_r <= tr4_r.sr * a2_ay_r;
      p3_m3_r <= tr4_r.cr * a2_az_r;
      p3_kx_r <= a2_kx_r;
      p3_ky_r <= a2_ky_r;
      p3_kz_r <= a2_kz_r;
      p3_ax_r <= a2_ax_r;
      tr5_r   <= tr4_r;

      a3_ay_r <= leg_fk_pkg::rnd30($signed({p3_m0_r[PW-1], p3_m0_r})
                                   - $signed({p3_m1_r[PW-1], p3_m1_r}));
      a3_az_r <= leg_fk_pkg::rnd30($signed({p3_m2_r[PW-1], p3_m2_r})
                                   + $signed({p3_m3_r[PW-1], p3_m3_r}));
      a3_kx_r <= p3_kx_r;
      a3_ky_r <= p3_ky_r;
      a3_kz_r <= p3_kz_r;
      a3_ax_r <= p3_ax_r;
      tr6_r   <= tr5_r;

      // Ankle hip pitch.
      p4_n0_r <= tr6_r.cp * a3_ax_r;
      p4_n1_r <= tr6_r.sp * a3_az_r;
      p4_n2_r <= tr6_r.sp * a3_ax_r;
      p4_n3_r <= tr6_r.cp * a3_az_r;
      p4_kx_r <= a3_kx_r;
      p4_ky_r <= a3_ky_r;
      p4_kz_r <= a3_kz_r;
      p4_ay_r <= a3_ay_r;

      a4_ax_r <= leg_fk_pkg::rnd30($signed({p4_n0_r[PW-1], p4_n0_r})
                                   + $signed({p4_n1_r[PW-1], p4_n1_r}));
      a4_az_r <= leg_fk_pkg::rnd30($signed({p4_n3_r[PW-1], p4_n3_r})
                                   - $signed({p4_n2_r[PW-1], p4_n2_r}));
      a4_kx_r <= p4_kx_r;
      a4_ky_r <= p4_ky_r;
      a4_kz_r <= p4_kz_r;
      a4_ay_r <= p4_ay_r;
    end
  end

  logic signed [EW-1:0]  off_e;
  logic signed [EW-1:0]  kx_e, ky_e, kz_e;
  logic signed [EW-1:0]  ax_e, ay_e, az_e;
  logic signed [POS-1:0] knee_x_r, knee_y_r, knee_z_r;
  logic signed [POS-1:0] ankle_x_r, ankle_y_r, ankle_z_r;

  always_comb begin
    off_e = $signed({{(EW-LW){1'b0}}, offset_r});
    if (sd_r[8]) begin
      off_e = -off_e;
    end
    kx_e = EW'(leg_fk_pkg::q16(a4_kx_r));
    ky_e = EW'(leg_fk_pkg::q16(a4_ky_r)) + off_e;
    kz_e = EW'(leg_fk_pkg::q16(a4_kz_r));
    ax_e = kx_e + EW'(leg_fk_pkg::q16(a4_ax_r));
    ay_e = ky_e + EW'(leg_fk_pkg::q16(a4_ay_r));
    az_e = kz_e + EW'(leg_fk_pkg::q16(a4_az_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pv_r[8];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      knee_x_r  <= leg_fk_pkg::sat(kx_e);
      knee_y_r  <= leg_fk_pkg::sat(ky_e);
      knee_z_r  <= leg_fk_pkg::sat(kz_e);
      ankle_x_r <= leg_fk_pkg::sat(ax_e);
      ankle_y_r <= leg_fk_pkg::sat(ay_e);
      ankle_z_r <= leg_fk_pkg::sat(az_e);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_knee_x  = knee_x_r;
  assign out_knee_y  = knee_y_r;
  assign out_knee_z  = knee_z_r;
  assign out_ankle_x = ankle_x_r;
  assign out_ankle_y = ankle_y_r;
  assign out_ankle_z = ankle_z_r;

`ifndef SYNTHESIS
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> cv_r[0])
    else $error("accepted item did not enter the CORDIC pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(cv_r) && $stable(pv_r))
    else $error("pipeline valid bits moved while stalled");

  a_join: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> pv_r[0] == $past(cv_r[NS]))
    else $error("item lost between CORDIC and rotation pipeline");

  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> out_valid == $past(pv_r[8]))
    else $error("item lost at the output stage");
`endif

endmodule
